FILE: hdl/csis_pkg.sv
// Shared types, opcodes and reset values for the CPU instruction step block.
// Used by every module under hdl; depends on nothing else.
package csis_pkg;

    localparam int STACK_ENTRIES = 256;
    localparam int STACK_AW      = $clog2(STACK_ENTRIES);

    typedef logic [STACK_AW-1:0] t_stack_addr;

    // Opcodes
    localparam logic [7:0] OP_BRK     = 8'h00;
    localparam logic [7:0] OP_LDA_IMM = 8'hA9;
    localparam logic [7:0] OP_LDX_IMM = 8'hA2;
    localparam logic [7:0] OP_LDY_IMM = 8'hA0;
    localparam logic [7:0] OP_JMP_ABS = 8'h4C;
    localparam logic [7:0] OP_STA_ABS = 8'h8D;
    localparam logic [7:0] OP_STA_ABY = 8'h99;
    localparam logic [7:0] OP_TXA     = 8'h8A;
    localparam logic [7:0] OP_PHA     = 8'h48;
    localparam logic [7:0] OP_PLA     = 8'h68;
    localparam logic [7:0] OP_INX     = 8'hE8;
    localparam logic [7:0] OP_INY     = 8'hC8;
    localparam logic [7:0] OP_DEX     = 8'hCA;
    localparam logic [7:0] OP_CPX_IMM = 8'hE0;
    localparam logic [7:0] OP_CPY_IMM = 8'hC0;
    localparam logic [7:0] OP_BNE     = 8'hD0;

    // Status flag bit positions
    localparam int FLAG_N = 7;
    localparam int FLAG_Z = 1;
    localparam int FLAG_C = 0;

    localparam logic [7:0]  STACK_PAGE  = 8'h01;
    localparam logic [15:0] RESET_PC    = 16'h0000;
    localparam logic [7:0]  RESET_SP    = 8'hFF;
    localparam logic [7:0]  RESET_FLAGS = 8'h20;

    typedef enum logic [1:0] {
        OUTCOME_EXEC = 2'd0,
        OUTCOME_BRK  = 2'd1,
        OUTCOME_SKIP = 2'd2
    } t_outcome;

    typedef struct packed {
        logic [15:0] pc;
        logic [7:0]  acc;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  sp;
        logic [7:0]  flags;
    } t_arch;

    // Field order matches the stream word: opcode in the lowest bits
    typedef struct packed {
        logic [7:0] operand_high;
        logic [7:0] operand_low;
        logic [7:0] opcode;
    } t_item;

    typedef struct packed {
        t_outcome    outcome;
        logic [7:0]  write_data;
        logic [15:0] write_address;
        logic        write_enable;
        logic [7:0]  flag_bits;
        logic [7:0]  y_value;
        logic [7:0]  x_value;
        logic [7:0]  acc_value;
        logic [15:0] next_pc;
    } t_result;

    localparam int IN_BYTES  = ($bits(t_item) + 7) / 8;
    localparam int OUT_BYTES = ($bits(t_result) + 7) / 8;

    typedef struct packed {
        logic        en;
        t_stack_addr addr;
        logic [7:0]  data;
    } t_stack_wr;

endpackage

FILE: hdl/cpu_subset_instruction_step.sv
// Top level of the CPU subset instruction step: input register, execute, result register.
// Depends on csis_pkg, csis_exec and csis_stack.
//
//  channel  | dir | payload (low bit first)
//  s_axis   | in  | opcode, operand_low, operand_high (24 bits)
//  m_axis   | out | next_pc, acc, x, y, flags, write_enable, write_address,
//           |     | write_data, outcome (75 bits, zero padded to 80)
//
// One instruction per cycle while the result register is not stalled; each instruction passes
// through the input register and then the result register.
// The execute stage runs when the input register is full and the result register
// is empty or being drained; the registered stack page read at SP+1 is issued ahead of its use.
// Reset (i_rst_n low, synchronous) empties both registers, restores A, X, Y, SP, flags
// and PC, and marks every stack entry as zero. A stalled result holds the pipe.
module cpu_subset_instruction_step
    import csis_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_BYTES*8-1:0]  s_axis_tdata,   // opcode, operand_low, operand_high
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_BYTES*8-1:0] m_axis_tdata    // next_pc, acc_value, x_value, y_value,
                                                   // flag_bits, write_enable, write_address,
                                                   // write_data, outcome
);

    logic        r_in_valid;
    t_item       r_in_item;
    logic        r_out_valid;
    t_result     r_out_result;
    t_arch       r_arch;

    t_arch       n_arch;
    t_result     exec_result;
    t_stack_wr   exec_wr;
    t_stack_wr   stack_wr;
    logic [7:0]  stack_top;
    logic [7:0]  sp_after;
    t_stack_addr rd_addr;
    logic        exec_fire;

    assign exec_fire     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || exec_fire;

    csis_exec u_exec (
        .i_arch      (r_arch),
        .i_item      (r_in_item),
        .i_stack_top (stack_top),
        .o_arch      (n_arch),
        .o_result    (exec_result),
        .o_stack_wr  (exec_wr)
    );

    always_comb begin
        stack_wr    = exec_wr;
        stack_wr.en = exec_wr.en && exec_fire;
        sp_after    = (exec_fire ? n_arch.sp : r_arch.sp) + 8'd1;
        rd_addr     = t_stack_addr'(sp_after);
    end

    csis_stack u_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (stack_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (stack_top)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_arch.pc    <= RESET_PC;
            r_arch.acc   <= 8'h00;
            r_arch.x     <= 8'h00;
            r_arch.y     <= 8'h00;
            r_arch.sp    <= RESET_SP;
            r_arch.flags <= RESET_FLAGS;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (exec_fire) begin
                r_out_valid <= 1'b1;
                r_arch      <= n_arch;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item <= t_item'(s_axis_tdata[$bits(t_item)-1:0]);
        end
        if (exec_fire) begin
            r_out_result <= exec_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_BYTES*8-$bits(t_result)){1'b0}}, r_out_result};

endmodule

FILE: hdl/csis_stack.sv
// Stack page copy: one write and one registered read per cycle.
// Valid bits stand in for the reset clear; depends on csis_pkg.
module csis_stack
    import csis_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_stack_wr   i_wr,
    input  t_stack_addr i_rd_addr,
    output logic [7:0]  o_rd_data
);

    logic [7:0]               r_mem [STACK_ENTRIES];
    logic [STACK_ENTRIES-1:0] r_valid;
    logic [7:0]               r_rd_data;
    logic                     r_rd_valid;
    logic                     bypass;

    assign bypass = i_wr.en && (i_wr.addr == i_rd_addr);

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        // forward a write to the same entry in this cycle
        r_rd_data <= bypass ? i_wr.data : r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            r_rd_valid <= bypass || r_valid[i_rd_addr];
        end
    end

    // never-written entries read as zero
    assign o_rd_data = r_rd_valid ? r_rd_data : 8'h00;

endmodule

FILE: hdl/csis_exec.sv
// Instruction decode and execute: next register state, result and stack write.
// Purely combinational; depends on csis_pkg.
module csis_exec
    import csis_pkg::*;
(
    input  t_arch      i_arch,
    input  t_item      i_item,
    input  logic [7:0] i_stack_top,
    output t_arch      o_arch,
    output t_result    o_result,
    output t_stack_wr  o_stack_wr
);

    function automatic logic [7:0] zn_flags(input logic [7:0] f, input logic [7:0] v);
        logic [7:0] r;
        r         = f;
        r[FLAG_Z] = (v == 8'h00);
        r[FLAG_N] = v[7];
        return r;
    endfunction

    function automatic logic [7:0] cmp_flags(input logic [7:0] f, input logic [7:0] reg_v,
                                             input logic [7:0] val);
        logic [7:0] r;
        logic [7:0] diff;
        diff      = reg_v - val;
        r         = f;
        r[FLAG_Z] = (reg_v == val);
        r[FLAG_C] = (reg_v >= val);
        r[FLAG_N] = diff[7];
        return r;
    endfunction

    logic [15:0] abs_addr;
    logic [15:0] sta_addr;
    logic [15:0] branch_off;
    logic [7:0]  lo;

    assign lo         = i_item.operand_low;
    assign abs_addr   = {i_item.operand_high, lo};
    assign sta_addr   = (i_item.opcode == OP_STA_ABY) ? abs_addr + {8'h00, i_arch.y} : abs_addr;
    assign branch_off = {{8{lo[7]}}, lo};

    always_comb begin
        t_arch      n;
        logic       we;
        logic [15:0] waddr;
        logic [7:0] wdata;
        t_outcome   outc;

        n          = i_arch;
        n.pc       = i_arch.pc + 16'd1;
        we         = 1'b0;
        waddr      = 16'h0000;
        wdata      = 8'h00;
        outc       = OUTCOME_EXEC;
        o_stack_wr = '0;

        case (i_item.opcode)
            OP_BRK: begin
                outc = OUTCOME_BRK;
            end
            OP_LDA_IMM: begin
                n.acc   = lo;
                n.flags = zn_flags(i_arch.flags, lo);
                n.pc    = i_arch.pc + 16'd2;
            end
            OP_LDX_IMM: begin
                n.x     = lo;
                n.flags = zn_flags(i_arch.flags, lo);
                n.pc    = i_arch.pc + 16'd2;
            end
            OP_LDY_IMM: begin
                n.y     = lo;
                n.flags = zn_flags(i_arch.flags, lo);
                n.pc    = i_arch.pc + 16'd2;
            end
            OP_JMP_ABS: begin
                n.pc = abs_addr;
            end
            OP_STA_ABS, OP_STA_ABY: begin
                we    = 1'b1;
                waddr = sta_addr;
                wdata = i_arch.acc;
                n.pc  = i_arch.pc + 16'd3;
                // mirror stores into the stack page
                if (sta_addr[15:8] == STACK_PAGE) begin
                    o_stack_wr.en   = 1'b1;
                    o_stack_wr.addr = t_stack_addr'(sta_addr[7:0]);
                    o_stack_wr.data = i_arch.acc;
                end
            end
            OP_TXA: begin
                n.acc   = i_arch.x;
                n.flags = zn_flags(i_arch.flags, i_arch.x);
            end
            OP_PHA: begin
                we              = 1'b1;
                waddr           = {STACK_PAGE, i_arch.sp};
                wdata           = i_arch.acc;
                o_stack_wr.en   = 1'b1;
                o_stack_wr.addr = t_stack_addr'(i_arch.sp);
                o_stack_wr.data = i_arch.acc;
                n.sp            = i_arch.sp - 8'd1;
            end
            OP_PLA: begin
                n.sp    = i_arch.sp + 8'd1;
                n.acc   = i_stack_top;
                n.flags = zn_flags(i_arch.flags, i_stack_top);
            end
            OP_INX: begin
                n.x     = i_arch.x + 8'd1;
                n.flags = zn_flags(i_arch.flags, n.x);
            end
            OP_INY: begin
                n.y     = i_arch.y + 8'd1;
                n.flags = zn_flags(i_arch.flags, n.y);
            end
            OP_DEX: begin
                n.x     = i_arch.x - 8'd1;
                n.flags = zn_flags(i_arch.flags, n.x);
            end
            OP_CPX_IMM: begin
                n.flags = cmp_flags(i_arch.flags, i_arch.x, lo);
                n.pc    = i_arch.pc + 16'd2;
            end
            OP_CPY_IMM: begin
                n.flags = cmp_flags(i_arch.flags, i_arch.y, lo);
                n.pc    = i_arch.pc + 16'd2;
            end
            OP_BNE: begin
                n.pc = i_arch.flags[FLAG_Z] ? i_arch.pc + 16'd2
                                            : i_arch.pc + 16'd2 + branch_off;
            end
            default: begin
                outc = OUTCOME_SKIP;
            end
        endcase

        o_arch                 = n;
        o_result.next_pc       = n.pc;
        o_result.acc_value     = n.acc;
        o_result.x_value       = n.x;
        o_result.y_value       = n.y;
        o_result.flag_bits     = n.flags;
        o_result.write_enable  = we;
        o_result.write_address = waddr;
        o_result.write_data    = wdata;
        o_result.outcome       = outc;
    end

endmodule

FILE: hdl/csis_check.sv
// Port-level checks for cpu_subset_instruction_step, attached by bind.
// Depends on csis_pkg for the result layout.
module csis_check
    import csis_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_BYTES*8-1:0] m_axis_tdata
);

    t_result res;
    assign res = t_result'(m_axis_tdata[$bits(t_result)-1:0]);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_no_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !res.write_enable |->
            res.write_address == 16'h0000 && res.write_data == 8'h00)
        else $error("write fields set without write enable");

    a_unused_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> res.flag_bits[5])
        else $error("unused flag bit cleared");

    a_outcome_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.outcome != OUTCOME_EXEC |-> !res.write_enable)
        else $error("break or skipped opcode wrote memory");

endmodule

bind cpu_subset_instruction_step csis_check u_csis_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for cpu_subset_instruction_step: drives instructions over the input stream
// and checks every result against an in-bench model of the CPU state.
// Depends on csis_pkg and the RTL under hdl.
module tb_top;
    import csis_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_BYTES*8-1:0]  s_axis_tdata;   // opcode, operand_low, operand_high
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_BYTES*8-1:0] m_axis_tdata;   // next_pc, acc_value, x_value, y_value, flag_bits,
                                            // write_enable, write_address, write_data, outcome

    // Model of the architectural state
    logic [15:0] cpu_pc;
    logic [7:0]  cpu_a;
    logic [7:0]  cpu_x;
    logic [7:0]  cpu_y;
    logic [7:0]  cpu_sp;
    logic [7:0]  cpu_flags;
    logic [7:0]  stack_copy [STACK_ENTRIES];

    t_result expected_steps[$];
    t_result seen_step;
    t_result want_step;

    int  error_count;
    int  cycle_count;
    int  rx_hold_request;
    bit  tx_idling;
    bit  rx_idling;

    cpu_subset_instruction_step dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_steps.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] with_zn(input logic [7:0] f, input logic [7:0] v);
        f[FLAG_Z] = (v == 8'h00);
        f[FLAG_N] = v[7];
        return f;
    endfunction

    function automatic logic [7:0] compare_flags(input logic [7:0] f, input logic [7:0] reg_val,
                                                 input logic [7:0] imm);
        logic [7:0] diff;
        diff = reg_val - imm;
        f[FLAG_Z] = (reg_val == imm);
        f[FLAG_C] = (reg_val >= imm);
        f[FLAG_N] = diff[7];
        return f;
    endfunction

    // Advance the CPU model by one instruction and return the result it must produce
    function automatic t_result execute_instruction(input t_item it);
        t_result     r;
        logic [15:0] target;
        r = '0;
        r.outcome = OUTCOME_EXEC;
        target = {it.operand_high, it.operand_low};
        case (it.opcode)
            OP_BRK: begin
                cpu_pc = cpu_pc + 16'd1;
                r.outcome = OUTCOME_BRK;
            end
            OP_LDA_IMM: begin
                cpu_a = it.operand_low;
                cpu_flags = with_zn(cpu_flags, cpu_a);
                cpu_pc = cpu_pc + 16'd2;
            end
            OP_LDX_IMM: begin
                cpu_x = it.operand_low;
                cpu_flags = with_zn(cpu_flags, cpu_x);
                cpu_pc = cpu_pc + 16'd2;
            end
            OP_LDY_IMM: begin
                cpu_y = it.operand_low;
                cpu_flags = with_zn(cpu_flags, cpu_y);
                cpu_pc = cpu_pc + 16'd2;
            end
            OP_JMP_ABS: cpu_pc = target;
            OP_STA_ABS, OP_STA_ABY: begin
                if (it.opcode == OP_STA_ABY)
                    target = target + {8'h00, cpu_y};
                r.write_enable = 1'b1;
                r.write_address = target;
                r.write_data = cpu_a;
                // a store into page one lands in the stack copy too
                if (target[15:8] == STACK_PAGE)
                    stack_copy[target[7:0]] = cpu_a;
                cpu_pc = cpu_pc + 16'd3;
            end
            OP_TXA: begin
                cpu_a = cpu_x;
                cpu_flags = with_zn(cpu_flags, cpu_a);
                cpu_pc = cpu_pc + 16'd1;
            end
            OP_PHA: begin
                r.write_enable = 1'b1;
                r.write_address = {STACK_PAGE, cpu_sp};
                r.write_data = cpu_a;
                stack_copy[cpu_sp] = cpu_a;
                cpu_sp = cpu_sp - 8'd1;
                cpu_pc = cpu_pc + 16'd1;
            end
            OP_PLA: begin
                cpu_sp = cpu_sp + 8'd1;
                cpu_a = stack_copy[cpu_sp];
                cpu_flags = with_zn(cpu_flags, cpu_a);
                cpu_pc = cpu_pc + 16'd1;
            end
            OP_INX: begin
                cpu_x = cpu_x + 8'd1;
                cpu_flags = with_zn(cpu_flags, cpu_x);
                cpu_pc = cpu_pc + 16'd1;
            end
            OP_INY: begin
                cpu_y = cpu_y + 8'd1;
                cpu_flags = with_zn(cpu_flags, cpu_y);
                cpu_pc = cpu_pc + 16'd1;
            end
            OP_DEX: begin
                cpu_x = cpu_x - 8'd1;
                cpu_flags = with_zn(cpu_flags, cpu_x);
                cpu_pc = cpu_pc + 16'd1;
            end
            OP_CPX_IMM: begin
                cpu_flags = compare_flags(cpu_flags, cpu_x, it.operand_low);
                cpu_pc = cpu_pc + 16'd2;
            end
            OP_CPY_IMM: begin
                cpu_flags = compare_flags(cpu_flags, cpu_y, it.operand_low);
                cpu_pc = cpu_pc + 16'd2;
            end
            OP_BNE: begin
                if (!cpu_flags[FLAG_Z])
                    cpu_pc = cpu_pc + 16'd2 + {{8{it.operand_low[7]}}, it.operand_low};
                else
                    cpu_pc = cpu_pc + 16'd2;
            end
            default: begin
                cpu_pc = cpu_pc + 16'd1;
                r.outcome = OUTCOME_SKIP;
            end
        endcase
        r.next_pc = cpu_pc;
        r.acc_value = cpu_a;
        r.x_value = cpu_x;
        r.y_value = cpu_y;
        r.flag_bits = cpu_flags;
        return r;
    endfunction

    function automatic logic [7:0] known_opcode(input int idx);
        case (idx)
            0:       return OP_BRK;
            1:       return OP_LDA_IMM;
            2:       return OP_LDX_IMM;
            3:       return OP_LDY_IMM;
            4:       return OP_JMP_ABS;
            5:       return OP_STA_ABS;
            6:       return OP_STA_ABY;
            7:       return OP_TXA;
            8:       return OP_PHA;
            9:       return OP_PLA;
            10:      return OP_INX;
            11:      return OP_INY;
            12:      return OP_DEX;
            13:      return OP_CPX_IMM;
            14:      return OP_CPY_IMM;
            default: return OP_BNE;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer with valid held
    task automatic issue_instruction(input logic [7:0] op, input logic [7:0] lo,
                                     input logic [7:0] hi);
        t_item item;
        int    gap;
        item.opcode = op;
        item.operand_low = lo;
        item.operand_high = hi;
        gap = tx_idling ? idle_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= item;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        expected_steps.push_back(execute_instruction(item));
        @(negedge i_clk);
    endtask

    task automatic issue_random_instruction();
        logic [7:0] op;
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'($urandom_range(0, 255));
        hi = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 12)
            op = 8'($urandom_range(0, 255));
        else
            op = known_opcode($urandom_range(0, 15));
        // steer some stores into page one so later pulls see them
        if ((op == OP_STA_ABS || op == OP_STA_ABY) && $urandom_range(0, 2) == 0)
            hi = STACK_PAGE;
        if (op == OP_CPX_IMM && $urandom_range(0, 3) == 0)
            lo = cpu_x;
        if (op == OP_CPY_IMM && $urandom_range(0, 3) == 0)
            lo = cpu_y;
        issue_instruction(op, lo, hi);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_steps.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= 10)
                $display("mismatch in %s: expected %h, got %h", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_step = m_axis_tdata[$bits(t_result)-1:0];
            if (expected_steps.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("result with nothing expected: %h", seen_step);
            end else begin
                want_step = expected_steps.pop_front();
                compare_field("next_pc", want_step.next_pc, seen_step.next_pc);
                compare_field("acc_value", 16'(want_step.acc_value),
                              16'(seen_step.acc_value));
                compare_field("x_value", 16'(want_step.x_value), 16'(seen_step.x_value));
                compare_field("y_value", 16'(want_step.y_value), 16'(seen_step.y_value));
                compare_field("flag_bits", 16'(want_step.flag_bits),
                              16'(seen_step.flag_bits));
                compare_field("write_enable", 16'(want_step.write_enable),
                              16'(seen_step.write_enable));
                compare_field("write_address", want_step.write_address,
                              seen_step.write_address);
                compare_field("write_data", 16'(want_step.write_data),
                              16'(seen_step.write_data));
                compare_field("outcome", 16'(want_step.outcome), 16'(seen_step.outcome));
            end
        end
    end

    // Result side: random stalls, plus a long hold-off counted here on request
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_request > 0) begin
                hold_left = rx_hold_request;
                rx_hold_request = 0;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (rx_idling && $urandom_range(0, 4) == 0)
                    stall_left = idle_gap();
            end
        end
    end

    task automatic test_reset_state();
        issue_instruction(OP_BRK, 8'h00, 8'h00);
        issue_instruction(OP_PLA, 8'h00, 8'h00);   // stack pointer wraps up, reads reset zero
        issue_instruction(8'hFF, 8'hFF, 8'hFF);
        issue_instruction(8'h02, 8'h00, 8'h00);
    endtask

    task automatic test_loads_and_flags();
        issue_instruction(OP_LDA_IMM, 8'h80, 8'hFF);
        issue_instruction(OP_LDA_IMM, 8'h00, 8'h00);
        issue_instruction(OP_LDX_IMM, 8'hFF, 8'h00);
        issue_instruction(OP_LDY_IMM, 8'h7F, 8'h00);
        issue_instruction(OP_TXA, 8'h00, 8'h00);
    endtask

    task automatic test_index_wrap();
        issue_instruction(OP_INX, 8'h00, 8'h00);   // FF -> 00
        issue_instruction(OP_DEX, 8'h00, 8'h00);   // 00 -> FF
        issue_instruction(OP_INY, 8'h00, 8'h00);
    endtask

    task automatic test_compares();
        issue_instruction(OP_CPX_IMM, 8'hFF, 8'h00);
        issue_instruction(OP_CPY_IMM, 8'h00, 8'h00);
        issue_instruction(OP_CPY_IMM, 8'hFF, 8'h00);
    endtask

    task automatic test_branches();
        issue_instruction(OP_BNE, 8'h80, 8'h00);   // taken, farthest back
        issue_instruction(OP_LDA_IMM, 8'h00, 8'h00);
        issue_instruction(OP_BNE, 8'h10, 8'h00);   // not taken
        issue_instruction(OP_LDX_IMM, 8'h01, 8'h00);
        issue_instruction(OP_BNE, 8'h7F, 8'h00);   // taken, farthest forward
        issue_instruction(OP_JMP_ABS, 8'hFF, 8'hFF);
        issue_instruction(OP_INY, 8'h00, 8'h00);   // program counter wraps to zero
    endtask

    task automatic test_stores_and_stack();
        issue_instruction(OP_LDA_IMM, 8'hA5, 8'h00);
        issue_instruction(OP_STA_ABY, 8'hFF, 8'hFF);   // address + Y wraps
        issue_instruction(OP_PHA, 8'h00, 8'h00);       // SP 00 -> FF
        issue_instruction(OP_PLA, 8'h00, 8'h00);
        issue_instruction(OP_LDA_IMM, 8'h3C, 8'h00);
        issue_instruction(OP_STA_ABS, 8'h01, 8'h01);   // page one, slot that PLA reads next
        issue_instruction(OP_PLA, 8'h00, 8'h00);
        issue_instruction(OP_STA_ABS, 8'h00, 8'h00);
    endtask

    task automatic test_random_program(input int count);
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        repeat (count) issue_random_instruction();
    endtask

    task automatic test_back_to_back(input int count);
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        repeat (count) issue_random_instruction();
    endtask

    task automatic test_receiver_hold_off();
        tx_idling = 1'b0;
        rx_idling = 1'b1;
        rx_hold_request = 200;
        repeat (40) issue_random_instruction();
    endtask

    task automatic test_sender_pause();
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        repeat (30) issue_random_instruction();
        wait_drained();
        repeat (30) issue_random_instruction();
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        error_count = 0;
        cycle_count = 0;
        rx_hold_request = 0;
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        cpu_pc = RESET_PC;
        cpu_a = 8'h00;
        cpu_x = 8'h00;
        cpu_y = 8'h00;
        cpu_sp = RESET_SP;
        cpu_flags = RESET_FLAGS;
        stack_copy = '{default: 8'h00};
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_loads_and_flags();
        test_index_wrap();
        test_compares();
        test_branches();
        test_stores_and_stack();
        test_back_to_back(150);
        test_random_program(500);
        test_receiver_hold_off();
        test_sender_pause();

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (error_count == 0 && expected_steps.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: files.f
hdl/csis_pkg.sv
hdl/csis_stack.sv
hdl/csis_exec.sv
hdl/cpu_subset_instruction_step.sv
hdl/csis_check.sv
test/tb_top.sv
